/* hdl/sitda_pkg.sv */
// shared types and constants for the signed integer to decimal ascii converter
// no dependencies; used by sitda_dd_stage and signed_int_to_decimal_ascii_top
package sitda_pkg;

	localparam int BinWidth      = 32;
	localparam int NumDigits     = 10;
	localparam int BcdWidth      = 4 * NumDigits;
	localparam int DdStages      = 4;
	localparam int ItersPerStage = BinWidth / DdStages;
	localparam int IdxWidth      = $clog2(NumDigits);

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharMinus = 8'h2d;

	// word carried through the binary to bcd pipeline
	typedef struct packed {
		logic                neg;
		logic [BcdWidth-1:0] bcd;
		logic [BinWidth-1:0] bin;
	} dd_word_t;

endpackage

/* hdl/sitda_dd_stage.sv */
// one registered stage of the shift-and-add-3 binary to bcd conversion
// depends on sitda_pkg (word type, iteration count per stage)
module sitda_dd_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sitda_pkg::dd_word_t in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output sitda_pkg::dd_word_t out_word
);

	logic                valid_s1;
	sitda_pkg::dd_word_t word_s1;
	sitda_pkg::dd_word_t step_word;

	// stage accepts when empty or when its word leaves this cycle
	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_word  = word_s1;

	// several shift-and-add-3 iterations, one input bit each
	always_comb begin
		step_word = in_word;
		for (int it = 0; it < sitda_pkg::ItersPerStage; it++) begin
			for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
				if (step_word.bcd[4*d +: 4] >= 4'd5) begin
					step_word.bcd[4*d +: 4] = step_word.bcd[4*d +: 4] + 4'd3;
				end
			end
			{step_word.bcd, step_word.bin} = {step_word.bcd[sitda_pkg::BcdWidth-2:0],
				step_word.bin, 1'b0};
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= step_word;
		end
	end

endmodule

/* hdl/signed_int_to_decimal_ascii_top.sv */
// signed 32-bit integer to decimal ascii characters, one character per word
// depends on sitda_pkg and sitda_dd_stage
// path: the first character of a value is shown from the serializer register after the value passes
// the sign/magnitude register and four bcd conversion stages of 8 bits each
// throughput: one character per cycle while out_ready is high; a value gives 1 to 11 characters,
// its character count; the pipeline takes a new value every cycle while not stalled
// reset: arst_n clears all valid bits and the character serializer, no words are kept
module signed_int_to_decimal_ascii_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  character,
	output logic        last
);

	localparam int Nd = sitda_pkg::NumDigits;
	localparam int Iw = sitda_pkg::IdxWidth;

	// sign and magnitude stage
	logic                valid_s1;
	sitda_pkg::dd_word_t word_s1;
	logic                ready_s1;

	// chain of conversion stages, entry 0 is the sign stage
	logic                dd_valid [sitda_pkg::DdStages+1];
	logic                dd_ready [sitda_pkg::DdStages+1];
	sitda_pkg::dd_word_t dd_word  [sitda_pkg::DdStages+1];

	// character serializer
	logic                  busy_q;
	logic                  sign_q;
	logic [Iw-1:0]         idx_q;
	logic [sitda_pkg::BcdWidth-1:0] bcd_q;
	logic                  ser_ready;
	logic                  ser_load;
	logic [Iw-1:0]         lead_idx;
	logic [3:0]            cur_digit;
	logic                  bcd_ok;

	assign ready_s1 = !valid_s1 || dd_ready[0];
	assign in_ready = ready_s1;

	// sign and magnitude, taken modulo 2^32 so the most negative value works
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			word_s1.neg <= value[31];
			word_s1.bcd <= '0;
			word_s1.bin <= value[31] ? (32'd0 - value) : value;
		end
	end

	assign dd_valid[0] = valid_s1;
	assign dd_word[0]  = word_s1;

	// binary to bcd pipeline
	for (genvar g = 0; g < sitda_pkg::DdStages; g++) begin : g_dd
		sitda_dd_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dd_valid[g]),
			.in_ready  (dd_ready[g]),
			.in_word   (dd_word[g]),
			.out_valid (dd_valid[g+1]),
			.out_ready (dd_ready[g+1]),
			.out_word  (dd_word[g+1])
		);
	end

	// position of the most significant nonzero digit, zero for a zero value
	always_comb begin
		lead_idx = '0;
		for (int d = 0; d < Nd; d++) begin
			if (dd_word[sitda_pkg::DdStages].bcd[4*d +: 4] != 4'd0) begin
				lead_idx = Iw'(d);
			end
		end
	end

	// serializer takes the next value as the last character of the current one leaves
	assign ser_ready = !busy_q || (out_ready && last);
	assign ser_load  = dd_valid[sitda_pkg::DdStages] && ser_ready;
	assign dd_ready[sitda_pkg::DdStages] = ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (ser_load) begin
			busy_q <= 1'b1;
			sign_q <= dd_word[sitda_pkg::DdStages].neg;
			idx_q  <= lead_idx;
		end else if (busy_q && out_ready) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			bcd_q <= dd_word[sitda_pkg::DdStages].bcd;
		end
	end

	// output character select
	always_comb begin
		cur_digit = 4'd0;
		for (int d = 0; d < Nd; d++) begin
			if (idx_q == Iw'(d)) begin
				cur_digit = bcd_q[4*d +: 4];
			end
		end
	end

	assign out_valid = busy_q;
	assign character = sign_q ? sitda_pkg::CharMinus : (sitda_pkg::CharZero + {4'd0, cur_digit});
	assign last      = !sign_q && (idx_q == '0);

	// every stored digit is a decimal digit
	always_comb begin
		bcd_ok = 1'b1;
		for (int d = 0; d < Nd; d++) begin
			if (bcd_q[4*d +: 4] > 4'd9) begin
				bcd_ok = 1'b0;
			end
		end
	end

	// checks
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == sitda_pkg::CharMinus) ||
			((character >= sitda_pkg::CharZero) && (character <= sitda_pkg::CharZero + 8'd9)))
		else $error("character is neither minus nor a digit");

	a_digit_after_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && sign_q |=> out_valid && !sign_q)
		else $error("minus sign not followed by a digit");

	a_bcd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> bcd_ok)
		else $error("serializer holds a non-decimal digit");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sign_q |-> !last)
		else $error("minus sign flagged as last character");

endmodule
